@@ rtl/ttdr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ttdr_pkg;

    localparam int unsigned TT_ENTRIES_DEF = 65536;
    localparam int unsigned QUEUE_DEPTH    = 2;

    localparam logic [7:0] EMPTY_MOVE_RST = 8'hFF;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_PROBE = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [1:0] BOUND_EXACT   = 2'd0;
    localparam logic [1:0] BOUND_INVALID = 2'd3;

    localparam logic signed [6:0] DEPTH_EMPTY = -7'sd1;

    typedef enum logic [1:0] {
        KIND_STORE = 2'd0,
        KIND_PROBE = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        logic [7:0]         move;
        logic [1:0]         bound;
        logic signed [15:0] score;
        logic [5:0]         depth;
        logic [63:0]        hash;
        logic [1:0]         op;
    } item_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [63:0]        hash;
        logic [5:0]         depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [7:0]         move;
    } cmd_t;

    typedef struct packed {
        logic [63:0]        tag;
        logic signed [6:0]  depth;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [7:0]         move;
    } entry_t;

    typedef struct packed {
        logic               done_res;
        logic [7:0]         found_move;
        logic [1:0]         found_bound;
        logic signed [15:0] found_score;
        logic               hit;
        logic               tag_match;
    } res_t;

    function automatic entry_t cleared_entry(input logic [7:0] code);
        entry_t e;
        e.tag   = '0;
        e.depth = DEPTH_EMPTY;
        e.score = '0;
        e.bound = BOUND_EXACT;
        e.move  = code;
        return e;
    endfunction

    function automatic res_t empty_result(input logic [7:0] code);
        res_t r;
        r.done_res    = 1'b1;
        r.found_move  = code;
        r.found_bound = BOUND_EXACT;
        r.found_score = '0;
        r.hit         = 1'b0;
        r.tag_match   = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ttdr_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttdr_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != FULL_CNT);
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/ttdr_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttdr_front
    import ttdr_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TT_ENTRIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire item_t                             s_item,
    input  wire logic                              hold,
    output logic                                   q_valid,
    input  wire logic                              q_ready,
    output cmd_t                                   q_cmd,
    output logic [$clog2(TABLE_ENTRIES)-1:0]       q_slot
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam logic [32:0] MOD_N = 33'(TABLE_ENTRIES);
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(TABLE_ENTRIES));

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_QUOT = 4'b0010,
        F_REM  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t      state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [2:0]        byte_cnt_reg, byte_cnt_next;
    logic [7:0]        quot_reg, quot_next;
    logic [7:0]        hash_byte;
    logic [31:0]       part_val;
    logic [63:0]       recip_prod;
    logic [32:0]       rem_val;
    logic              take;
    cmd_kind_t         kind_in;

    assign s_ready = !hold && ((state_reg == F_IDLE) || ((state_reg == F_PUSH) && q_ready));
    assign take    = s_valid && s_ready;
    assign q_valid = (state_reg == F_PUSH);
    assign q_cmd   = cmd_reg;
    assign q_slot  = slot_reg;

    always_comb begin
        case (s_item.op)
            OP_STORE: kind_in = KIND_STORE;
            OP_PROBE: kind_in = KIND_PROBE;
            OP_CLEAR: kind_in = KIND_CLEAR;
            default:  kind_in = KIND_NOP;
        endcase
    end

    // The remainder is built one hash byte at a time from the top. The partial
    // value is below 256 times the table size, so the scaled reciprocal gives a
    // quotient that is at most one short, and one compare and subtract fixes it.
    assign hash_byte  = cmd_reg.hash[{byte_cnt_reg, 3'b000} +: 8];
    assign part_val   = 32'({slot_reg, hash_byte});
    assign recip_prod = {32'd0, part_val} * {32'd0, RECIP};

    always_comb begin
        rem_val = {1'b0, part_val} - (33'(quot_reg) * MOD_N);
        if (rem_val >= MOD_N) begin
            rem_val = rem_val - MOD_N;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        slot_next     = slot_reg;
        byte_cnt_next = byte_cnt_reg;
        quot_next     = quot_reg;
        case (state_reg)
            F_IDLE: begin
                state_next = F_IDLE;
            end
            F_QUOT: begin
                quot_next  = recip_prod[39:32];
                state_next = F_REM;
            end
            F_REM: begin
                slot_next = rem_val[IDX_W-1:0];
                if (byte_cnt_reg == '0) begin
                    state_next = F_PUSH;
                end else begin
                    byte_cnt_next = byte_cnt_reg - 1'b1;
                    state_next    = F_QUOT;
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
        if (take) begin
            cmd_next.kind  = kind_in;
            cmd_next.hash  = s_item.hash;
            cmd_next.depth = s_item.depth;
            cmd_next.score = s_item.score;
            cmd_next.bound = s_item.bound;
            cmd_next.move  = s_item.move;
            if (IS_POW2) begin
                slot_next  = s_item.hash[IDX_W-1:0];
                state_next = F_PUSH;
            end else if ((kind_in == KIND_STORE) || (kind_in == KIND_PROBE)) begin
                slot_next     = '0;
                byte_cnt_next = 3'd7;
                state_next    = F_QUOT;
            end else begin
                slot_next  = '0;
                state_next = F_PUSH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        slot_reg     <= slot_next;
        byte_cnt_reg <= byte_cnt_next;
        quot_reg     <= quot_next;
    end

endmodule

`default_nettype wire

@@ rtl/ttdr_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttdr_back
    import ttdr_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TT_ENTRIES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              q_valid,
    output logic                                   q_ready,
    input  wire cmd_t                              q_cmd,
    input  wire logic [$clog2(TABLE_ENTRIES)-1:0]  q_slot,
    input  wire logic [7:0]                        empty_move,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output res_t                                   m_res,
    output logic                                   clearing
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_LOOK  = 4'b0010,
        B_RESP  = 4'b0100,
        B_CLEAR = 4'b1000
    } back_state_t;

    entry_t mem [TABLE_ENTRIES];

    back_state_t       state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [IDX_W-1:0]  cur_slot_reg, cur_slot_next;
    logic [IDX_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [7:0]        clr_code_reg, clr_code_next;
    logic              clr_op_reg, clr_op_next;
    logic              m_valid_reg, m_valid_next;
    res_t              res_reg, res_next;
    entry_t            rd_data_reg;

    logic              mem_re, mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic              out_free, out_load;
    logic              tag_eq;
    logic signed [6:0] ask_depth;
    res_t              res_new;

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_res     = res_reg;
    assign clearing  = (state_reg == B_CLEAR);
    assign tag_eq    = (rd_data_reg.tag == cur_reg.hash);
    assign ask_depth = signed'({1'b0, cur_reg.depth});

    always_comb begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        cur_slot_next = cur_slot_reg;
        clr_addr_next = clr_addr_reg;
        clr_code_next = clr_code_reg;
        clr_op_next   = clr_op_reg;
        q_ready       = 1'b0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = cur_slot_reg;
        mem_wdata.tag   = cur_reg.hash;
        mem_wdata.depth = ask_depth;
        mem_wdata.score = cur_reg.score;
        mem_wdata.bound = cur_reg.bound;
        mem_wdata.move  = cur_reg.move;
        out_load      = 1'b0;
        res_new       = empty_result(empty_move);
        case (state_reg)
            B_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    cur_next      = q_cmd;
                    cur_slot_next = q_slot;
                    case (q_cmd.kind)
                        KIND_STORE, KIND_PROBE: begin
                            mem_re     = 1'b1;
                            state_next = B_LOOK;
                        end
                        KIND_CLEAR: begin
                            clr_code_next = empty_move;
                            clr_addr_next = '0;
                            clr_op_next   = 1'b1;
                            state_next    = B_CLEAR;
                        end
                        default: begin
                            state_next = B_RESP;
                        end
                    endcase
                end
            end
            B_LOOK: begin
                // The read word stays put while the result waits for room.
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                    if (cur_reg.kind == KIND_STORE) begin
                        mem_we = !tag_eq || (rd_data_reg.depth <= ask_depth);
                    end else if (tag_eq) begin
                        res_new.tag_match  = 1'b1;
                        res_new.found_move = rd_data_reg.move;
                        if ((rd_data_reg.depth >= ask_depth)
                                && (rd_data_reg.bound != BOUND_INVALID)) begin
                            res_new.hit         = 1'b1;
                            res_new.found_score = rd_data_reg.score;
                            res_new.found_bound = rd_data_reg.bound;
                        end
                    end
                end
            end
            B_RESP: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = cleared_entry(clr_code_reg);
                if (clr_addr_reg == LAST_SLOT) begin
                    state_next = clr_op_reg ? B_RESP : B_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        res_next     = res_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            res_next     = res_new;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_CLEAR;
            clr_addr_reg <= '0;
            clr_code_reg <= EMPTY_MOVE_RST;
            clr_op_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            clr_code_reg <= clr_code_next;
            clr_op_reg   <= clr_op_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        cur_slot_reg <= cur_slot_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[q_slot];
        end
    end

endmodule

`default_nettype wire

@@ rtl/transposition_table_depth_replace_top.sv @@
// Direct-mapped transposition table with depth-preferred replacement. Each word on
// the slave side is a store, probe or clear (s_tuser), or an unused code; every
// word gives exactly one result word on the master side, in order. After reset the
// table is swept to its empty contents, one slot per cycle, with s_tready low; a
// clear word repeats that sweep before its result. A store or probe occupies the
// table sequencer for a registered read of the single-port slot memory, then the
// compare and write-back; the sequencer takes no new word until it is done with
// the last; the compare step waits while a finished result is not taken. When
// TABLE_ENTRIES is not a power of two the slot index is the hash remainder, worked
// out one hash byte at a time (a multiply by the scaled reciprocal of the table
// size, then a subtract and one correction) in the front end, for stores and
// probes. Up to QUEUE_DEPTH classified words wait between front end and sequencer,
// and the result register lets a new word in while a finished result waits.
`timescale 1ns / 1ps
`default_nettype none

module transposition_table_depth_replace_top
    import ttdr_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = TT_ENTRIES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pos_hash[63:0], depth[69:64], entry_score[85:70], bound_kind[87:86],
    // entry_move[95:88]
    input  wire logic [95:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tag_match[0], hit[1], found_score[17:2], found_bound[19:18], found_move[27:20],
    // done_res[28], zero fill [31:29]
    output logic [31:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    // empty_move_code[7:0]
    input  wire logic [7:0]  cfg_data
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned Q_W   = $bits(cmd_t) + IDX_W;

    item_t            s_item;
    logic [7:0]       empty_move_reg;
    logic             clearing;
    logic             fq_valid, fq_ready, bq_valid, bq_ready;
    cmd_t             fq_cmd, bq_cmd;
    logic [IDX_W-1:0] fq_slot, bq_slot;
    logic [Q_W-1:0]   bq_data;
    res_t             res;

    assign s_item.op    = s_tuser;
    assign s_item.hash  = s_tdata[63:0];
    assign s_item.depth = s_tdata[69:64];
    assign s_item.score = s_tdata[85:70];
    assign s_item.bound = s_tdata[87:86];
    assign s_item.move  = s_tdata[95:88];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_move_reg <= EMPTY_MOVE_RST;
        end else if (cfg_valid && cfg_ready) begin
            empty_move_reg <= cfg_data;
        end
    end

    ttdr_front #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .hold    (clearing),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_cmd   (fq_cmd),
        .q_slot  (fq_slot)
    );

    ttdr_fifo #(
        .WIDTH(Q_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_slot, fq_cmd}),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    assign bq_cmd  = bq_data[$bits(cmd_t)-1:0];
    assign bq_slot = bq_data[Q_W-1:$bits(cmd_t)];

    ttdr_back #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (bq_valid),
        .q_ready    (bq_ready),
        .q_cmd      (bq_cmd),
        .q_slot     (bq_slot),
        .empty_move (empty_move_reg),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (res),
        .clearing   (clearing)
    );

    assign m_tdata = {3'b000, res.done_res, res.found_move, res.found_bound,
                      res.found_score, res.hit, res.tag_match};

endmodule

`default_nettype wire

@@ rtl/ttdr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ttdr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // Every result word acknowledges its item.
    a_done_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[28])
        else $error("result word without done flag");

    // A hit is only possible on a matching tag.
    a_hit_needs_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> m_tdata[0])
        else $error("hit reported without tag match");

    // Score and bound are zero unless the word is a hit.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[1]) |-> (m_tdata[19:2] == 18'd0))
        else $error("score or bound set on a miss");

    // The table sweep after reset keeps the input closed.
    a_reset_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

endmodule

bind transposition_table_depth_replace_top ttdr_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import ttdr_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;
    localparam int         HASH_POOL   = 40;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    // Shadow of the table: only slots written since the last wipe are kept,
    // every other slot reads as cleared with the code in force at that wipe.
    entry_t      slot_mem [int unsigned];
    logic [7:0]  empty_code = EMPTY_MOVE_RST;
    logic [7:0]  wipe_code  = EMPTY_MOVE_RST;
    res_t        pending_results [$];
    logic [63:0] known_hashes [HASH_POOL];

    int send_idle_pct = 12;
    int recv_idle_pct = 61;
    int hold_left     = 0;
    int bad_words     = 0;

    transposition_table_depth_replace_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge aclk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic res_t apply_to_table(input logic [1:0] op, input logic [63:0] hash,
                                            input logic [5:0] depth, input logic [15:0] score,
                                            input logic [1:0] bound, input logic [7:0] move);
        res_t        r;
        entry_t      e;
        int unsigned slot;
        slot          = int'(hash % 64'(TT_ENTRIES_DEF));
        r.done_res    = 1'b1;
        r.found_move  = empty_code;
        r.found_bound = BOUND_EXACT;
        r.found_score = '0;
        r.hit         = 1'b0;
        r.tag_match   = 1'b0;
        if (slot_mem.exists(slot)) begin
            e = slot_mem[slot];
        end else begin
            e.tag   = '0;
            e.depth = DEPTH_EMPTY;
            e.score = '0;
            e.bound = BOUND_EXACT;
            e.move  = wipe_code;
        end
        case (op)
            OP_STORE: begin
                if (e.tag != hash || $signed(e.depth) <= $signed({1'b0, depth})) begin
                    e.tag   = hash;
                    e.depth = {1'b0, depth};
                    e.score = score;
                    e.bound = bound;
                    e.move  = move;
                    slot_mem[slot] = e;
                end
            end
            OP_PROBE: begin
                if (e.tag == hash) begin
                    r.tag_match  = 1'b1;
                    r.found_move = e.move;
                    if ($signed(e.depth) >= $signed({1'b0, depth}) && e.bound != BOUND_INVALID) begin
                        r.hit         = 1'b1;
                        r.found_score = e.score;
                        r.found_bound = e.bound;
                    end
                end
            end
            OP_CLEAR: begin
                slot_mem.delete();
                wipe_code = empty_code;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        bad_words++;
        if (bad_words <= 10) begin
            $display("[%0t] %s mismatch: expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : check_results
        res_t want;
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = res_t'(m_tdata[28:0]);
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result word", 64'd0, 64'(m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (got.tag_match !== want.tag_match)
                    note_mismatch("tag_match", 64'(want.tag_match), 64'(got.tag_match));
                if (got.hit !== want.hit)
                    note_mismatch("hit", 64'(want.hit), 64'(got.hit));
                if (got.found_score !== want.found_score)
                    note_mismatch("found_score", {48'd0, want.found_score},
                                  {48'd0, got.found_score});
                if (got.found_bound !== want.found_bound)
                    note_mismatch("found_bound", 64'(want.found_bound), 64'(got.found_bound));
                if (got.found_move !== want.found_move)
                    note_mismatch("found_move", 64'(want.found_move), 64'(got.found_move));
                if (got.done_res !== want.done_res)
                    note_mismatch("done_res", 64'(want.done_res), 64'(got.done_res));
                if (m_tdata[31:29] !== 3'b000)
                    note_mismatch("zero fill", 64'd0, 64'(m_tdata[31:29]));
            end
        end
    end

    // Valid stays high after acceptance; the next call or the drain decides
    // whether it drops at the following falling edge.
    task automatic send_word(input logic [1:0] op, input logic [63:0] hash,
                             input logic [5:0] depth, input logic [15:0] score,
                             input logic [1:0] bound, input logic [7:0] move);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {move, bound, score, depth, hash};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(apply_to_table(op, hash, depth, score, bound, move));
    endtask

    task automatic send_random_word();
        int          pick;
        logic [1:0]  op;
        logic [1:0]  bound;
        logic [63:0] hash;
        pick = $urandom_range(99);
        op = (pick < 48) ? OP_STORE : (pick < 95) ? OP_PROBE : OP_UNUSED;
        if ($urandom_range(99) < 85) begin
            hash = known_hashes[$urandom_range(HASH_POOL - 1)];
        end else begin
            hash = {$urandom, $urandom};
        end
        bound = ($urandom_range(99) < 8) ? BOUND_INVALID : 2'($urandom_range(2));
        send_word(op, hash, 6'($urandom_range(63)), 16'($urandom), bound, 8'($urandom));
    endtask

    task automatic wait_all_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_empty_code(input logic [7:0] code);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        empty_code = code;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_cases();
        logic [63:0] h_a;
        logic [63:0] h_b;
        logic [63:0] h_c;
        logic [63:0] h_slot0;
        h_a     = 64'h0123_4567_89AB_1234;
        h_b     = 64'hFEDC_BA98_7654_1234;
        h_c     = 64'h8000_0000_0000_0042;
        h_slot0 = 64'h0000_0001_0000_0000;
        // Hash zero matches the cleared tag but the empty depth forbids a hit.
        send_word(OP_PROBE, 64'd0, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, h_a, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_STORE, h_a, 6'd10, 16'h8000, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, h_a, 6'd10, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, h_a, 6'd11, 16'h0, BOUND_EXACT, 8'h00);
        // A shallower store on the same tag must not replace the entry.
        send_word(OP_STORE, h_a, 6'd9, 16'h1234, BOUND_LOWER, 8'h33);
        send_word(OP_PROBE, h_a, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_STORE, h_a, 6'd10, 16'h7FFF, BOUND_UPPER, 8'hFF);
        send_word(OP_PROBE, h_a, 6'd10, 16'h0, BOUND_EXACT, 8'h00);
        // A different tag in the same slot always replaces, even at depth zero.
        send_word(OP_STORE, h_b, 6'd0, 16'h0001, BOUND_LOWER, 8'h5C);
        send_word(OP_PROBE, h_a, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, h_b, 6'd0, 16'hFFFF, BOUND_INVALID, 8'hFF);
        send_word(OP_STORE, h_c, 6'd63, 16'hFFFF, BOUND_INVALID, 8'hA5);
        send_word(OP_PROBE, h_c, 6'd63, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_STORE, h_slot0, 6'd0, 16'h4000, BOUND_LOWER, 8'h3C);
        send_word(OP_PROBE, 64'd0, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, h_slot0, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'h7FFF, BOUND_UPPER, 8'hFF);
        send_word(OP_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_UNUSED, h_c, 6'd63, 16'hFFFF, BOUND_INVALID, 8'hFF);
        send_word(OP_PROBE, h_c, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'hFFFF, BOUND_INVALID, 8'hFF);
        send_word(OP_PROBE, h_slot0, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, 64'd0, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        wait_all_results();
    endtask

    task automatic test_empty_code_change();
        logic [63:0] h_a;
        logic [63:0] h_b;
        h_a = 64'h0F0F_0F0F_0F0F_2222;
        h_b = 64'h7777_0000_1111_3333;
        send_word(OP_STORE, h_a, 6'd5, 16'h0BAD, BOUND_LOWER, 8'h11);
        wait_all_results();
        write_empty_code(8'h5A);
        // Entries written before the change, and slots cleared before it, keep
        // their old move values; misses report the new code.
        send_word(OP_PROBE, h_a, 6'd5, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, 64'd0, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, h_b, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_STORE, h_b, 6'd1, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_CLEAR, 64'd0, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, 64'd0, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_PROBE, h_a, 6'd0, 16'h0, BOUND_EXACT, 8'h00);
        send_word(OP_UNUSED, h_b, 6'd1, 16'h0, BOUND_EXACT, 8'h00);
        wait_all_results();
    endtask

    task automatic test_random_traffic(input int count, input int s_idle, input int r_idle,
                                       input logic [7:0] code);
        int clear_at;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        write_empty_code(code);
        clear_at = $urandom_range(count - 1);
        for (int i = 0; i < count; i++) begin
            if (i == clear_at) begin
                send_word(OP_CLEAR, {$urandom, $urandom}, 6'($urandom_range(63)),
                          16'($urandom), 2'($urandom_range(3)), 8'($urandom));
            end else begin
                send_random_word();
            end
        end
        wait_all_results();
    endtask

    // The receiver stops for a long stretch while words keep coming, so the
    // queue and result register fill up and the input side has to stall.
    task automatic test_result_stall();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(posedge aclk);
        hold_left = 400;
        for (int i = 0; i < 40; i++) begin
            send_random_word();
        end
        wait_all_results();
    endtask

    initial begin
        for (int i = 0; i < HASH_POOL; i++) begin
            known_hashes[i] = {$urandom, $urandom};
            if (i % 4 == 3) begin
                known_hashes[i][15:0] = known_hashes[i - 1][15:0];
            end
        end
        known_hashes[0] = '0;
        known_hashes[1] = '1;
        known_hashes[2] = {$urandom, 32'h0};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // The table sweeps itself empty after reset with the input held off.
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        test_directed_cases();
        test_empty_code_change();
        test_random_traffic(550, 12, 61, 8'h00);
        test_random_traffic(550, 61, 12, 8'hFF);
        test_random_traffic(550, 0, 0, 8'($urandom));
        test_result_stall();
        repeat (20) @(posedge aclk);
        if (bad_words == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ttdr_pkg.sv
rtl/ttdr_fifo.sv
rtl/ttdr_front.sv
rtl/ttdr_back.sv
rtl/transposition_table_depth_replace_top.sv
rtl/ttdr_checker.sv
dv/tb_top.sv
